// File: hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define VYVS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("vyvs assertion failed");

// antecedent implies consequent, overlapping or not as written in cons
`define VYVS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vyvs implication failed");

`endif

// File: hw/rtl/vyvs_pkg.sv
package vyvs_pkg;

    typedef enum logic [2:0] {
        REQ_CMD  = 3'd0,
        REQ_YAW  = 3'd1,
        REQ_MODE = 3'd2,
        REQ_LOOK = 3'd3,
        REQ_BAL  = 3'd4,
        REQ_TICK = 3'd5
    } req_type_t;

    typedef enum logic [2:0] {
        DRIVE_NONE  = 3'd0,
        DRIVE_MOVE  = 3'd1,
        DRIVE_STOP  = 3'd2,
        DRIVE_STAND = 3'd3,
        DRIVE_EULER = 3'd4
    } drive_kind_t;

    typedef enum logic [2:0] {
        CFG_LIMIT_VX   = 3'd0,
        CFG_LIMIT_VY   = 3'd1,
        CFG_LIMIT_WZ   = 3'd2,
        CFG_LOOK_GAIN  = 3'd3,
        CFG_CMD_TMO    = 3'd4,
        CFG_STATE_TMO  = 3'd5,
        CFG_LATERAL_EN = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_BSTAND, S_BEULER, S_VCMD, S_VH1, S_VH2,
        S_TRIG_X, S_T1, S_T2, S_T3, S_T4,
        S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4, S_ROT5,
        S_YAW1, S_YAW2, S_OUT
    } state_t;

    typedef struct packed {
        logic stop;
        logic chg;
        logic bal;
        logic init;
        logic recv;
    } flags_t;

    localparam int MUL_W = 33;
    localparam int PROD_W = 64;

    localparam logic [MUL_W-1:0] VH_SCALE = 33'd42723;
    localparam logic [15:0] TRIG_K1 = 16'd1160;
    localparam logic [15:0] TRIG_K2 = 16'd10512;
    localparam logic [15:0] TRIG_K3 = 16'd25736;
    localparam logic [MUL_W-1:0] YAW_K = 33'd25736;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [14:0] Q14_ONE = 15'd16384;

    // round half away from zero, then arithmetic shift
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v, input int unsigned s);
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[PROD_W-1] ? $signed(-m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] clamp16(
        input logic signed [PROD_W-1:0] v, input logic [14:0] lim);
        logic signed [PROD_W-1:0] l;
        logic signed [PROD_W-1:0] nl;
        l = $signed({49'd0, lim});
        nl = -l;
        if (v > l) begin
            return l[15:0];
        end else if (v < nl) begin
            return nl[15:0];
        end
        return v[15:0];
    endfunction

    function automatic logic signed [PROD_W-1:0] sx64(input logic signed [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] sx33(input logic signed [15:0] v);
        return {{17{v[15]}}, v};
    endfunction

endpackage

// File: hw/rtl/virtual_yaw_velocity_shaper_unit.sv
// Virtual yaw velocity shaper. Events come in on the slave stream (kind in s_tuser); all events
// except the tick update internal state in the cycle they are accepted and produce no
// transaction. A tick runs a sequencer around one registered 33x33 multiplier: with no yaw
// report, a stale report, or balance mode it finishes early; a velocity tick runs through
// virtual heading integration, sine and cosine at four products each, the rotation and the
// yaw tracker, and is bounded by that single multiplier. Then one to three result
// transactions go out, one per cycle while m_tready is high; s_tready is low from tick
// acceptance until the last result is taken. Configuration is written through the APB port.
module virtual_yaw_velocity_shaper_unit #(
    parameter int TRIG_BITS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_ms, cmd_vx, cmd_vy, cmd_wz, robot_yaw, mode_select, look_delta,
    // roll_in, pitch_in, heading_in
    input  logic [167:0] s_tdata,
    // req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // drive_vx, drive_vy, drive_wz, euler_roll, euler_pitch, euler_heading, yaw_offset
    output logic [111:0] m_tdata,
    // drive_kind
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vyvs_pkg::*;

    localparam logic [15:0] TRIG_RND  = 16'(1 << (15 - TRIG_BITS));
    localparam logic [15:0] TRIG_MASK = ~16'((1 << (16 - TRIG_BITS)) - 1);

    // input fields
    logic [31:0]        in_time;
    logic signed [15:0] in_vx, in_vy, in_wz, in_yaw, in_look, in_roll, in_pitch, in_head;
    logic               in_mode;

    assign in_time  = s_tdata[31:0];
    assign in_vx    = s_tdata[47:32];
    assign in_vy    = s_tdata[63:48];
    assign in_wz    = s_tdata[79:64];
    assign in_yaw   = s_tdata[95:80];
    assign in_mode  = s_tdata[96];
    assign in_look  = s_tdata[112:97];
    assign in_roll  = s_tdata[128:113];
    assign in_pitch = s_tdata[144:129];
    assign in_head  = s_tdata[160:145];

    // configuration
    logic [14:0] lim_vx_reg, lim_vy_reg, lim_wz_reg;
    logic [15:0] gain_reg, cmd_tmo_reg, st_tmo_reg;
    logic        lat_en_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_vx_reg  <= 15'd1638;
            lim_vy_reg  <= 15'd1024;
            lim_wz_reg  <= 15'd2458;
            gain_reg    <= 16'd6144;
            cmd_tmo_reg <= 16'd300;
            st_tmo_reg  <= 16'd500;
            lat_en_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx_t'(paddr[4:2]))
                CFG_LIMIT_VX:   lim_vx_reg  <= pwdata[14:0];
                CFG_LIMIT_VY:   lim_vy_reg  <= pwdata[14:0];
                CFG_LIMIT_WZ:   lim_wz_reg  <= pwdata[14:0];
                CFG_LOOK_GAIN:  gain_reg    <= pwdata[15:0];
                CFG_CMD_TMO:    cmd_tmo_reg <= pwdata[15:0];
                CFG_STATE_TMO:  st_tmo_reg  <= pwdata[15:0];
                CFG_LATERAL_EN: lat_en_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx_t'(paddr[4:2]))
            CFG_LIMIT_VX:   prdata = {17'd0, lim_vx_reg};
            CFG_LIMIT_VY:   prdata = {17'd0, lim_vy_reg};
            CFG_LIMIT_WZ:   prdata = {17'd0, lim_wz_reg};
            CFG_LOOK_GAIN:  prdata = {16'd0, gain_reg};
            CFG_CMD_TMO:    prdata = {16'd0, cmd_tmo_reg};
            CFG_STATE_TMO:  prdata = {16'd0, st_tmo_reg};
            CFG_LATERAL_EN: prdata = {31'd0, lat_en_reg};
            default:        prdata = '0;
        endcase
    end

    // architectural state
    state_t             state_reg, state_next;
    flags_t             flags_reg, flags_next;
    logic signed [15:0] held_vx_reg, held_vx_next, held_vy_reg, held_vy_next;
    logic signed [15:0] held_wz_reg, held_wz_next;
    logic [31:0]        cmd_stamp_reg, cmd_stamp_next, st_stamp_reg, st_stamp_next;
    logic [31:0]        tick_stamp_reg, tick_stamp_next;
    logic [15:0]        real_reg, real_next, look_reg, look_next;
    logic [31:0]        virt_reg, virt_next;
    logic [15:0]        bal_roll_reg, bal_roll_next, bal_pitch_reg, bal_pitch_next;
    logic [15:0]        bal_head_reg, bal_head_next;
    logic [1:0]         cnt_reg, cnt_next, idx_reg, idx_next;

    // working registers
    logic [31:0]        now_reg, now_next;
    logic [30:0]        dt_reg, dt_next;
    logic [14:0]        x_reg, x_next, x2_reg, x2_next;
    logic               neg_reg, neg_next, pass_reg, pass_next;
    logic signed [15:0] sin_reg, sin_next, cos_reg, cos_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [15:0] bx_reg, bx_next, by_reg, by_next;
    logic signed [15:0] va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    drive_kind_t        kind_reg [3];

    logic               push_en;
    drive_kind_t        push_kind;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    vyvs_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // derived values
    logic [31:0]        tick_diff, cmd_diff, st_diff;
    logic [30:0]        tick_dt;
    logic               cmd_stale, st_stale;
    logic signed [15:0] vx_c, vy_c, wz_c, err, bw;
    logic signed [PROD_W-1:0] vh_inc;
    logic [15:0]        ang, ang_q;
    logic [14:0]        x_calc;
    logic [14:0]        trig_r;
    logic signed [15:0] trig_s;

    assign tick_diff = in_time - tick_stamp_reg;
    assign tick_dt   = tick_diff[31] ? '0 : tick_diff[30:0];
    assign cmd_diff  = now_reg - cmd_stamp_reg;
    assign st_diff   = now_reg - st_stamp_reg;
    // negative age counts as fresh
    assign cmd_stale = !cmd_diff[31] && (cmd_diff > {16'd0, cmd_tmo_reg});
    assign st_stale  = !st_diff[31] && (st_diff > {16'd0, st_tmo_reg});

    assign vx_c = clamp16(sx64(held_vx_reg), lim_vx_reg);
    assign vy_c = lat_en_reg ? clamp16(sx64(held_vy_reg), lim_vy_reg) : '0;
    assign wz_c = clamp16(sx64(held_wz_reg), lim_wz_reg);
    assign err  = look_reg - real_reg;

    assign vh_inc = round_shift(prod, 8);
    assign bw     = clamp16(round_shift(prod, 28), lim_wz_reg);

    // quantize angle, fold into quarter wave
    assign ang    = virt_reg[31:16] - real_reg + (pass_reg ? QUARTER_TURN : 16'd0);
    assign ang_q  = (ang + TRIG_RND) & TRIG_MASK;
    assign x_calc = ang_q[14] ? Q14_ONE - {1'b0, ang_q[13:0]} : {1'b0, ang_q[13:0]};
    assign trig_r = prod[28:14];
    assign trig_s = neg_reg ? -$signed({1'b0, trig_r}) : $signed({1'b0, trig_r});

    always_comb begin
        state_next      = state_reg;
        flags_next      = flags_reg;
        held_vx_next    = held_vx_reg;
        held_vy_next    = held_vy_reg;
        held_wz_next    = held_wz_reg;
        cmd_stamp_next  = cmd_stamp_reg;
        st_stamp_next   = st_stamp_reg;
        tick_stamp_next = tick_stamp_reg;
        real_next       = real_reg;
        look_next       = look_reg;
        virt_next       = virt_reg;
        bal_roll_next   = bal_roll_reg;
        bal_pitch_next  = bal_pitch_reg;
        bal_head_next   = bal_head_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        dt_next         = dt_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        neg_next        = neg_reg;
        pass_next       = pass_reg;
        sin_next        = sin_reg;
        cos_next        = cos_reg;
        acc_next        = acc_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        vc_next         = vc_reg;
        push_en         = 1'b0;
        push_kind       = DRIVE_NONE;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (req_type_t'(s_tuser))
                        REQ_CMD: begin
                            held_vx_next   = in_vx;
                            held_vy_next   = in_vy;
                            held_wz_next   = in_wz;
                            cmd_stamp_next = in_time;
                        end
                        REQ_YAW: begin
                            real_next     = in_yaw;
                            st_stamp_next = in_time;
                            if (!flags_reg.init) begin
                                virt_next       = {in_yaw, 16'd0};
                                look_next       = in_yaw;
                                flags_next.init = 1'b1;
                            end
                            flags_next.recv = 1'b1;
                        end
                        REQ_MODE: begin
                            if (!in_mode) begin
                                if (flags_reg.bal) begin
                                    flags_next.bal  = 1'b0;
                                    flags_next.stop = 1'b0;
                                    flags_next.chg  = 1'b1;
                                    look_next       = real_reg;
                                end
                            end else if (!flags_reg.bal) begin
                                flags_next.bal  = 1'b1;
                                flags_next.stop = 1'b0;
                                flags_next.chg  = 1'b1;
                                bal_head_next   = real_reg;
                            end
                        end
                        REQ_LOOK: begin
                            if (flags_reg.init) begin
                                look_next = look_reg + in_look;
                            end
                        end
                        REQ_BAL: begin
                            bal_roll_next  = in_roll;
                            bal_pitch_next = in_pitch;
                            bal_head_next  = in_head;
                        end
                        REQ_TICK: begin
                            now_next        = in_time;
                            dt_next         = tick_dt;
                            tick_stamp_next = in_time;
                            cnt_next        = '0;
                            idx_next        = '0;
                            state_next      = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                if (!(flags_reg.recv && flags_reg.init)) begin
                    state_next = S_OUT;
                end else if (st_stale) begin
                    push_en         = !flags_reg.stop;
                    push_kind       = DRIVE_STOP;
                    flags_next.stop = 1'b1;
                    state_next      = S_OUT;
                end else if (flags_reg.bal) begin
                    if (flags_reg.chg) begin
                        push_en         = !flags_reg.stop;
                        push_kind       = DRIVE_STOP;
                        flags_next.stop = 1'b1;
                        flags_next.chg  = 1'b0;
                        state_next      = S_BSTAND;
                    end else begin
                        state_next = S_BEULER;
                    end
                end else begin
                    if (flags_reg.chg) begin
                        push_en         = !flags_reg.stop;
                        push_kind       = DRIVE_STOP;
                        flags_next.stop = 1'b1;
                        flags_next.chg  = 1'b0;
                    end
                    state_next = S_VCMD;
                end
            end
            S_BSTAND: begin
                push_en    = 1'b1;
                push_kind  = DRIVE_STAND;
                state_next = S_BEULER;
            end
            S_BEULER: begin
                push_en         = 1'b1;
                push_kind       = DRIVE_EULER;
                va_next         = bal_roll_reg;
                vb_next         = bal_pitch_reg;
                vc_next         = bal_head_reg;
                flags_next.stop = 1'b0;
                state_next      = S_OUT;
            end
            S_VCMD: begin
                if (cmd_stale) begin
                    push_en         = !flags_reg.stop;
                    push_kind       = DRIVE_STOP;
                    flags_next.stop = 1'b1;
                    state_next      = S_OUT;
                end else begin
                    mul_a      = sx33(wz_c);
                    mul_b      = VH_SCALE;
                    state_next = S_VH1;
                end
            end
            S_VH1: begin
                mul_a      = prod[MUL_W-1:0];
                mul_b      = {2'b00, dt_reg};
                state_next = S_VH2;
            end
            S_VH2: begin
                virt_next  = virt_reg + vh_inc[31:0];
                pass_next  = 1'b0;
                state_next = S_TRIG_X;
            end
            S_TRIG_X: begin
                x_next     = x_calc;
                neg_next   = ang_q[15];
                mul_a      = {18'd0, x_calc};
                mul_b      = {18'd0, x_calc};
                state_next = S_T1;
            end
            S_T1: begin
                x2_next    = prod[28:14];
                mul_a      = {17'd0, TRIG_K1};
                mul_b      = {18'd0, prod[28:14]};
                state_next = S_T2;
            end
            S_T2: begin
                mul_a      = {17'd0, TRIG_K2 - {5'd0, prod[24:14]}};
                mul_b      = {18'd0, x2_reg};
                state_next = S_T3;
            end
            S_T3: begin
                mul_a      = {17'd0, TRIG_K3 - {2'd0, prod[27:14]}};
                mul_b      = {18'd0, x_reg};
                state_next = S_T4;
            end
            S_T4: begin
                if (!pass_reg) begin
                    sin_next   = trig_s;
                    pass_next  = 1'b1;
                    state_next = S_TRIG_X;
                end else begin
                    cos_next   = trig_s;
                    state_next = S_ROT0;
                end
            end
            S_ROT0: begin
                mul_a      = sx33(cos_reg);
                mul_b      = sx33(vx_c);
                state_next = S_ROT1;
            end
            S_ROT1: begin
                acc_next   = prod;
                mul_a      = sx33(sin_reg);
                mul_b      = sx33(vy_c);
                state_next = S_ROT2;
            end
            S_ROT2: begin
                bx_next    = clamp16(round_shift(acc_reg - prod, 14), lim_vx_reg);
                mul_a      = sx33(sin_reg);
                mul_b      = sx33(vx_c);
                state_next = S_ROT3;
            end
            S_ROT3: begin
                acc_next   = prod;
                mul_a      = sx33(cos_reg);
                mul_b      = sx33(vy_c);
                state_next = S_ROT4;
            end
            S_ROT4: begin
                by_next    = clamp16(round_shift(acc_reg + prod, 14), lim_vy_reg);
                state_next = S_ROT5;
            end
            S_ROT5: begin
                mul_a      = {17'd0, gain_reg};
                mul_b      = sx33(err);
                state_next = S_YAW1;
            end
            S_YAW1: begin
                mul_a      = prod[MUL_W-1:0];
                mul_b      = YAW_K;
                state_next = S_YAW2;
            end
            S_YAW2: begin
                if (bx_reg == '0 && by_reg == '0 && bw == '0) begin
                    push_en         = !flags_reg.stop;
                    push_kind       = DRIVE_STOP;
                    flags_next.stop = 1'b1;
                end else begin
                    push_en         = 1'b1;
                    push_kind       = DRIVE_MOVE;
                    va_next         = bx_reg;
                    vb_next         = by_reg;
                    vc_next         = bw;
                    flags_next.stop = 1'b0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    if (m_tlast) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (push_en) begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            flags_reg      <= '0;
            held_vx_reg    <= '0;
            held_vy_reg    <= '0;
            held_wz_reg    <= '0;
            cmd_stamp_reg  <= '0;
            st_stamp_reg   <= '0;
            tick_stamp_reg <= '0;
            real_reg       <= '0;
            look_reg       <= '0;
            virt_reg       <= '0;
            bal_roll_reg   <= '0;
            bal_pitch_reg  <= '0;
            bal_head_reg   <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            flags_reg      <= flags_next;
            held_vx_reg    <= held_vx_next;
            held_vy_reg    <= held_vy_next;
            held_wz_reg    <= held_wz_next;
            cmd_stamp_reg  <= cmd_stamp_next;
            st_stamp_reg   <= st_stamp_next;
            tick_stamp_reg <= tick_stamp_next;
            real_reg       <= real_next;
            look_reg       <= look_next;
            virt_reg       <= virt_next;
            bal_roll_reg   <= bal_roll_next;
            bal_pitch_reg  <= bal_pitch_next;
            bal_head_reg   <= bal_head_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg  <= now_next;
        dt_reg   <= dt_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        neg_reg  <= neg_next;
        pass_reg <= pass_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        acc_reg  <= acc_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        va_reg   <= va_next;
        vb_reg   <= vb_next;
        vc_reg   <= vc_next;
        if (push_en) begin
            kind_reg[cnt_reg] <= push_kind;
        end
    end

    // result side
    drive_kind_t        out_kind;
    logic [1:0]         out_cnt;
    logic               is_move, is_euler;
    logic [15:0]        offs;

    assign out_cnt  = (cnt_reg == '0) ? 2'd1 : cnt_reg;
    assign out_kind = (cnt_reg == '0) ? DRIVE_NONE : kind_reg[idx_reg];
    assign is_move  = out_kind == DRIVE_MOVE;
    assign is_euler = out_kind == DRIVE_EULER;
    assign offs     = virt_reg[31:16] - real_reg;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tuser  = out_kind;
    assign m_tlast  = idx_reg == out_cnt - 2'd1;
    assign m_tdata  = {offs,
                       is_euler ? vc_reg : 16'sd0,
                       is_euler ? vb_reg : 16'sd0,
                       is_euler ? va_reg : 16'sd0,
                       is_move  ? vc_reg : 16'sd0,
                       is_move  ? vb_reg : 16'sd0,
                       is_move  ? va_reg : 16'sd0};

endmodule

// File: hw/rtl/vyvs_mul.sv
module vyvs_mul (
    input  logic                              aclk,
    input  logic signed [vyvs_pkg::MUL_W-1:0] mul_a,
    input  logic signed [vyvs_pkg::MUL_W-1:0] mul_b,
    output logic signed [vyvs_pkg::PROD_W-1:0] prod
);
    import vyvs_pkg::*;

    logic signed [2*MUL_W-1:0] full;

    assign full = mul_a * mul_b;

    // operands are bounded so the product always fits 64 bits
    always_ff @(posedge aclk) begin
        prod <= full[PROD_W-1:0];
    end

endmodule

// File: hw/rtl/vyvs_checker.sv
`include "assert_macros.svh"

module vyvs_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);
    import vyvs_pkg::*;

    // results only go out while the input side is closed
    `VYVS_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // a none result stands alone
    `VYVS_ASSERT_IMP(a_none_alone, aclk, aresetn, m_tvalid && m_tuser == DRIVE_NONE, m_tlast)
    // balance stand is always followed by an euler pose
    `VYVS_ASSERT_IMP(a_stand_not_last, aclk, aresetn, m_tvalid && m_tuser == DRIVE_STAND, !m_tlast)
    `VYVS_ASSERT_IMP(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid)
    `VYVS_ASSERT_IMP(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 $stable(m_tdata))

endmodule

bind virtual_yaw_velocity_shaper_unit vyvs_checker u_vyvs_checker (.*);

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vyvs_pkg::*;

    localparam int TB_TRIG_BITS = 10;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        req_type_t   kind;
        logic [31:0] time_ms;
        logic [15:0] vx, vy, wz, yaw;
        logic        mode;
        logic [15:0] look, roll, pitch, heading;
    } shaper_event_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] vx, vy, wz, roll, pitch, heading, offs;
        logic        last;
    } drive_out_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         psel, penable, pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    virtual_yaw_velocity_shaper_unit #(.TRIG_BITS(TB_TRIG_BITS)) dut (.*);

    // shadow of the configuration registers
    longint lim_vx, lim_vy, lim_wz, gain, cmd_tmo, yaw_tmo;
    bit     lat_en;

    // shadow of the block state
    longint      hold_vx, hold_vy, hold_wz;
    logic [31:0] cmd_ts, yaw_ts, tick_ts;
    logic [15:0] real_yaw, look_tgt, b_roll, b_pitch, b_head;
    logic [31:0] virt_yaw;
    bit          got_yaw, yaw_init, bal_mode, mode_chg, stop_sent;

    drive_out_t    drive_expected[$];
    drive_out_t    tick_outputs[$];
    shaper_event_t event_q[$];
    shaper_event_t cur_ev;

    bit          calm;
    int          mismatches;
    int          stall_cycles;
    logic [31:0] tnow;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint age_ms(logic [31:0] now, logic [31:0] stamp);
        int d;
        d = int'(now - stamp);
        return longint'(d);
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint sat(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint sine_q14(logic [15:0] ang);
        int unsigned q, a, quad, x, x2, t;
        q = ((32'(ang) + (1 << (15 - TB_TRIG_BITS))) >> (16 - TB_TRIG_BITS))
            & ((1 << TB_TRIG_BITS) - 1);
        a = (q << (16 - TB_TRIG_BITS)) & 16'hFFFF;
        quad = a >> 14;
        x = a & 16'h3FFF;
        if (quad[0]) begin
            x = 16384 - x;
        end
        x2 = (x * x) >> 14;
        t = 10512 - ((1160 * x2) >> 14);
        t = 25736 - ((t * x2) >> 14);
        t = (t * x) >> 14;
        return quad[1] ? -longint'(t) : longint'(t);
    endfunction

    function automatic drive_out_t mk_out(drive_kind_t k, longint a, longint b, longint c,
                                          bit euler);
        drive_out_t o;
        o = '0;
        o.kind = k;
        if (euler) begin
            o.roll = a[15:0]; o.pitch = b[15:0]; o.heading = c[15:0];
        end else begin
            o.vx = a[15:0]; o.vy = b[15:0]; o.wz = c[15:0];
        end
        return o;
    endfunction

    task automatic send_stop_once();
        if (!stop_sent) begin
            tick_outputs.push_back(mk_out(DRIVE_STOP, 0, 0, 0, 0));
            stop_sent = 1;
        end
    endtask

    task automatic shape_velocity(logic [31:0] now, longint dt);
        longint vx, vy, wz, bx, by, bw, sn, cs, err;
        logic [15:0] d;
        if (mode_chg) begin
            send_stop_once();
            mode_chg = 0;
        end
        if (age_ms(now, cmd_ts) > cmd_tmo) begin
            send_stop_once();
            return;
        end
        vx = sat(hold_vx, lim_vx);
        vy = lat_en ? sat(hold_vy, lim_vy) : 0;
        wz = sat(hold_wz, lim_wz);
        virt_yaw = virt_yaw + 32'(rnd_shift(wz * dt * 42723, 8));
        d = virt_yaw[31:16] - real_yaw;
        sn = sine_q14(d);
        cs = sine_q14(d + QUARTER_TURN);
        bx = sat(rnd_shift(cs * vx - sn * vy, 14), lim_vx);
        by = sat(rnd_shift(sn * vx + cs * vy, 14), lim_vy);
        err = longint'($signed(16'(look_tgt - real_yaw)));
        bw = sat(rnd_shift(gain * err * 25736, 28), lim_wz);
        if (bx == 0 && by == 0 && bw == 0) begin
            send_stop_once();
            return;
        end
        tick_outputs.push_back(mk_out(DRIVE_MOVE, bx, by, bw, 0));
        stop_sent = 0;
    endtask

    task automatic run_tick(logic [31:0] now);
        longint dt;
        dt = age_ms(now, tick_ts);
        if (dt < 0) begin
            dt = 0;
        end
        tick_ts = now;
        if (!(got_yaw && yaw_init)) begin
            return;
        end
        if (age_ms(now, yaw_ts) > yaw_tmo) begin
            send_stop_once();
        end else if (!bal_mode) begin
            shape_velocity(now, dt);
        end else begin
            if (mode_chg) begin
                send_stop_once();
                tick_outputs.push_back(mk_out(DRIVE_STAND, 0, 0, 0, 0));
                mode_chg = 0;
            end
            tick_outputs.push_back(mk_out(DRIVE_EULER, longint'($signed(b_roll)),
                longint'($signed(b_pitch)), longint'($signed(b_head)), 1));
            stop_sent = 0;
        end
    endtask

    // advance the shadow state by one accepted event, queue what it drives out
    task automatic apply_event(shaper_event_t ev);
        logic [15:0] offs;
        case (ev.kind)
            REQ_CMD: begin
                hold_vx = longint'($signed(ev.vx));
                hold_vy = longint'($signed(ev.vy));
                hold_wz = longint'($signed(ev.wz));
                cmd_ts = ev.time_ms;
            end
            REQ_YAW: begin
                real_yaw = ev.yaw;
                yaw_ts = ev.time_ms;
                if (!yaw_init) begin
                    virt_yaw = {ev.yaw, 16'd0};
                    look_tgt = ev.yaw;
                    yaw_init = 1;
                end
                got_yaw = 1;
            end
            REQ_MODE: begin
                if (!ev.mode) begin
                    if (bal_mode) begin
                        bal_mode = 0; stop_sent = 0; mode_chg = 1;
                        look_tgt = real_yaw;
                    end
                end else if (!bal_mode) begin
                    bal_mode = 1; stop_sent = 0; mode_chg = 1;
                    b_head = real_yaw;
                end
            end
            REQ_LOOK: begin
                if (yaw_init) begin
                    look_tgt = look_tgt + ev.look;
                end
            end
            REQ_BAL: begin
                b_roll = ev.roll; b_pitch = ev.pitch; b_head = ev.heading;
            end
            REQ_TICK: begin
                tick_outputs.delete();
                run_tick(ev.time_ms);
                if (tick_outputs.size() == 0) begin
                    tick_outputs.push_back(mk_out(DRIVE_NONE, 0, 0, 0, 0));
                end
                offs = virt_yaw[31:16] - real_yaw;
                foreach (tick_outputs[i]) begin
                    tick_outputs[i].offs = offs;
                    tick_outputs[i].last = (i == tick_outputs.size() - 1);
                    drive_expected.push_back(tick_outputs[i]);
                end
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                apply_event(cur_ev);
            end
            if (event_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
                cur_ev = event_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_ev.kind;
                s_tdata <= {7'd0, cur_ev.heading, cur_ev.pitch, cur_ev.roll, cur_ev.look,
                            cur_ev.mode, cur_ev.yaw, cur_ev.wz, cur_ev.vy, cur_ev.vx,
                            cur_ev.time_ms};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, checker and watchdog
    always @(posedge aclk) begin
        drive_out_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 33);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                       m_tdata[63:48], m_tdata[79:64], m_tdata[95:80], m_tdata[111:96],
                       m_tlast};
                if (drive_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transaction %h", got);
                    end
                end else begin
                    want = drive_expected.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: kind %0d/%0d v %h %h %h / %h %h %h",
                                     want.kind, got.kind, want.vx, want.vy, want.wz,
                                     got.vx, got.vy, got.wz);
                            $display("  euler %h %h %h / %h %h %h offs %h/%h last %b/%b",
                                     want.roll, want.pitch, want.heading, got.roll,
                                     got.pitch, got.heading, want.offs, got.offs,
                                     want.last, got.last);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (event_q.size() == 0 && !s_tvalid && drive_expected.size() == 0)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("[virtual_yaw_velocity_shaper_unit] ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic reg_write(cfg_idx_t idx, int unsigned val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            CFG_LIMIT_VX:   lim_vx = val & 16'h7FFF;
            CFG_LIMIT_VY:   lim_vy = val & 16'h7FFF;
            CFG_LIMIT_WZ:   lim_wz = val & 16'h7FFF;
            CFG_LOOK_GAIN:  gain = val & 16'hFFFF;
            CFG_CMD_TMO:    cmd_tmo = val & 16'hFFFF;
            CFG_STATE_TMO:  yaw_tmo = val & 16'hFFFF;
            CFG_LATERAL_EN: lat_en = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(int unsigned vx, int unsigned vy, int unsigned wz,
                             int unsigned g, int unsigned ct, int unsigned st,
                             int unsigned le);
        reg_write(CFG_LIMIT_VX, vx);
        reg_write(CFG_LIMIT_VY, vy);
        reg_write(CFG_LIMIT_WZ, wz);
        reg_write(CFG_LOOK_GAIN, g);
        reg_write(CFG_CMD_TMO, ct);
        reg_write(CFG_STATE_TMO, st);
        reg_write(CFG_LATERAL_EN, le);
    endtask

    task automatic wait_drained();
        wait (event_q.size() == 0 && !s_tvalid && drive_expected.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic push_ev(req_type_t k, int unsigned step, logic [15:0] a = 0,
                           logic [15:0] b = 0, logic [15:0] c = 0);
        shaper_event_t ev;
        tnow = tnow + step;
        ev.kind = k;
        ev.time_ms = tnow;
        ev.vx = 16'($urandom); ev.vy = 16'($urandom); ev.wz = 16'($urandom);
        ev.yaw = 16'($urandom);
        ev.mode = 1'($urandom); ev.look = 16'($urandom); ev.roll = 16'($urandom);
        ev.pitch = 16'($urandom); ev.heading = 16'($urandom);
        case (k)
            REQ_CMD:  begin ev.vx = a; ev.vy = b; ev.wz = c; end
            REQ_YAW:  ev.yaw = a;
            REQ_MODE: ev.mode = a[0];
            REQ_LOOK: ev.look = a;
            REQ_BAL:  begin ev.roll = a; ev.pitch = b; ev.heading = c; end
            default: ;
        endcase
        event_q.push_back(ev);
    endtask

    task automatic push_random(int n);
        int unsigned r;
        shaper_event_t ev;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_ev(REQ_TICK, $urandom_range(1, 60));
            end else if (r < 55) begin
                if ($urandom_range(0, 1)) begin
                    push_ev(REQ_CMD, $urandom_range(0, 40), 16'($urandom), 16'($urandom),
                            16'($urandom));
                end else begin
                    push_ev(REQ_CMD, $urandom_range(0, 40), 16'($urandom_range(0, 4000) - 2000),
                            16'($urandom_range(0, 4000) - 2000),
                            16'($urandom_range(0, 6000) - 3000));
                end
            end else if (r < 70) begin
                push_ev(REQ_YAW, $urandom_range(0, 40), 16'($urandom));
            end else if (r < 80) begin
                push_ev(REQ_LOOK, $urandom_range(0, 20), 16'($urandom));
            end else if (r < 87) begin
                push_ev(REQ_BAL, $urandom_range(0, 20), 16'($urandom), 16'($urandom),
                        16'($urandom));
            end else if (r < 93) begin
                push_ev(REQ_MODE, $urandom_range(0, 20), 16'($urandom));
            end else if (r < 96) begin
                // wild timestamp jump, forward, backward or anywhere
                tnow = $urandom;
                push_ev(REQ_TICK, 0);
            end else begin
                push_ev(REQ_TICK, $urandom_range(0, 5));
                ev = event_q.pop_back();
                ev.kind = req_type_t'($urandom_range(6, 7));
                event_q.push_back(ev);
            end
        end
    endtask

    initial begin
        shaper_event_t ev;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        calm = 0; mismatches = 0; stall_cycles = 0; tnow = 32'd100;
        lim_vx = 1638; lim_vy = 1024; lim_wz = 2458; gain = 6144;
        cmd_tmo = 300; yaw_tmo = 500; lat_en = 0;
        hold_vx = 0; hold_vy = 0; hold_wz = 0;
        cmd_ts = 0; yaw_ts = 0; tick_ts = 0;
        real_yaw = 0; look_tgt = 0; b_roll = 0; b_pitch = 0; b_head = 0; virt_yaw = 0;
        got_yaw = 0; yaw_init = 0; bal_mode = 0; mode_chg = 0; stop_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: before first yaw report, then extremes and mode changes
        push_ev(REQ_TICK, 5);
        push_ev(REQ_LOOK, 1, 16'h1234);
        push_ev(REQ_YAW, 1, 16'h7FFF);
        push_ev(REQ_CMD, 1, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_ev(REQ_TICK, 20);
        push_ev(REQ_CMD, 1, 16'h8000, 16'h7FFF, 16'h8000);
        push_ev(REQ_TICK, 20);
        push_ev(REQ_LOOK, 1, 16'h8000);
        push_ev(REQ_TICK, 20);
        push_ev(REQ_CMD, 1, 16'h0000, 16'h0000, 16'h0000);
        push_ev(REQ_LOOK, 1, 16'h8000);
        push_ev(REQ_TICK, 20);
        push_ev(REQ_TICK, 20);
        push_ev(REQ_TICK, 400);
        push_ev(REQ_MODE, 1, 16'd1);
        push_ev(REQ_MODE, 1, 16'd1);
        push_ev(REQ_BAL, 1, 16'h8000, 16'h7FFF, 16'hFFFF);
        push_ev(REQ_TICK, 10);
        push_ev(REQ_MODE, 1, 16'd0);
        push_ev(REQ_CMD, 1, 16'd500, 16'd0, 16'd0);
        push_ev(REQ_TICK, 10);
        push_ev(REQ_TICK, 700);
        push_ev(REQ_TICK, 32'hFFFF_FF00);
        push_ev(REQ_TICK, 0);
        ev = event_q.pop_back();
        ev.kind = req_type_t'(7);
        event_q.push_back(ev);
        wait_drained();

        write_all(32767, 32767, 32767, 65535, 65535, 65535, 1);
        push_ev(REQ_YAW, 1, 16'($urandom));
        push_random(80);
        wait_drained();

        write_all(0, 0, 0, 0, 0, 0, 1);
        calm = 1;
        push_ev(REQ_YAW, 1, 16'($urandom));
        push_random(70);
        wait_drained();
        calm = 0;

        write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(0, 65535),
                  $urandom_range(20, 400), $urandom_range(20, 400), 1);
        push_ev(REQ_YAW, 1, 16'($urandom));
        push_random(80);
        wait_drained();

        write_all(3000, 2000, 4000, 20000, 300, 500, 0);
        push_ev(REQ_YAW, 1, 16'($urandom));
        push_random(80);
        wait_drained();

        if (mismatches == 0 && drive_expected.size() == 0) begin
            $display("[virtual_yaw_velocity_shaper_unit] OK");
        end else begin
            $display("[virtual_yaw_velocity_shaper_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
